// ===== rtl/bltf_pkg.sv =====
// ----------------------------------------------------------------------------
// bltf_pkg
// Types, constants and the gamma lookup shared by the backlight fader blocks.
// ----------------------------------------------------------------------------
package bltf_pkg;

  localparam int LEVEL_COUNT     = 17;
  localparam int MAX_LEVEL       = LEVEL_COUNT - 1;
  localparam int LVL_W           = $clog2(LEVEL_COUNT) + 1;  // signed, one code for off
  localparam int FADE_STEP_LIMIT = 4;
  localparam int DIM_RESET       = 10;
  localparam int TIMEOUT_RESET   = 15;

  localparam int GAMMA_SIZE = 17;
  localparam int GIDX_W     = $clog2(GAMMA_SIZE);
  localparam logic [7:0] GAMMA [GAMMA_SIZE] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd13, 8'd21, 8'd32,
    8'd45, 8'd62, 8'd83, 8'd108, 8'd137, 8'd171, 8'd210, 8'd255
  };

  localparam logic signed [LVL_W-1:0] LVL_OFF = '1;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHT  = 2'd0,
    CFG_DIM     = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] time_now;
    logic        relay_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] intensity;
    logic       light_off;
    logic       fade_pending;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [4:0] bright_level;
    logic [4:0] dim_level;
    logic [7:0] timeout_seconds;
  } cfg_t;

  // up to two results produced by one request
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  function automatic logic [7:0] gamma_of(logic signed [LVL_W-1:0] lvl);
    logic [7:0] g;
    if (lvl < 0) begin
      g = 8'd0;
    end else if (lvl >= GAMMA_SIZE) begin
      g = GAMMA[GAMMA_SIZE-1];
    end else begin
      g = GAMMA[GIDX_W'($unsigned(lvl))];
    end
    return g;
  endfunction

endpackage

// ===== rtl/bltf_cfg.sv =====
// ----------------------------------------------------------------------------
// bltf_cfg
// Configuration registers with level saturation and dim-to-bright clamping.
// ----------------------------------------------------------------------------
module bltf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bltf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output bltf_pkg::cfg_t                cfg
);

  logic [4:0] wr_lvl;
  logic [4:0] bright_sat;
  logic [4:0] dim_sat;

  assign wr_lvl     = cfg_data[4:0];
  assign bright_sat = (int'(wr_lvl) > bltf_pkg::MAX_LEVEL) ? 5'(bltf_pkg::MAX_LEVEL) : wr_lvl;
  assign dim_sat    = (wr_lvl > cfg.bright_level) ? cfg.bright_level : wr_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bright_level    <= 5'(bltf_pkg::MAX_LEVEL);
      cfg.dim_level       <= (bltf_pkg::DIM_RESET < bltf_pkg::MAX_LEVEL) ?
                             5'(bltf_pkg::DIM_RESET) : 5'(bltf_pkg::MAX_LEVEL);
      cfg.timeout_seconds <= 8'(bltf_pkg::TIMEOUT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        bltf_pkg::CFG_BRIGHT: begin
          cfg.bright_level <= bright_sat;
          // lowering bright pulls dim down with it
          if (cfg.dim_level > bright_sat) begin
            cfg.dim_level <= bright_sat;
          end
        end
        bltf_pkg::CFG_DIM: begin
          cfg.dim_level <= dim_sat;
        end
        bltf_pkg::CFG_TIMEOUT: begin
          cfg.timeout_seconds <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/bltf_step.sv =====
// ----------------------------------------------------------------------------
// bltf_step
// Input register, fader state and the per-request level step logic.
// ----------------------------------------------------------------------------
module bltf_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bltf_pkg::in_item_t in_data,
  input  bltf_pkg::cfg_t     cfg,
  input  logic               room,
  output bltf_pkg::push_t    push
);

  logic                             in_full;
  bltf_pkg::in_item_t               item;
  logic signed [bltf_pkg::LVL_W-1:0] level_now;
  logic [31:0]                      last_time;

  logic                             load;
  logic                             advance;
  logic [31:0]                      elapsed;
  logic signed [bltf_pkg::LVL_W-1:0] bright_s;
  logic signed [bltf_pkg::LVL_W-1:0] dim_s;
  logic signed [bltf_pkg::LVL_W-1:0] target;
  logic signed [bltf_pkg::LVL_W-1:0] level_dn;
  logic signed [bltf_pkg::LVL_W-1:0] level_next;
  logic [7:0]                       g_hi;
  logic [7:0]                       g_lo;
  logic [7:0]                       g_min;
  logic [7:0]                       g_diff;
  logic [7:0]                       g_mid;
  bltf_pkg::out_item_t              fin;

  assign advance  = in_full & room;
  assign in_stall = in_full & ~room;
  assign load     = in_valid & ~in_stall;

  assign bright_s = $signed(bltf_pkg::LVL_W'(cfg.bright_level));
  assign dim_s    = $signed(bltf_pkg::LVL_W'(cfg.dim_level));
  assign elapsed  = item.time_now - last_time;

  always_comb begin
    if (item.mode) begin
      target = bright_s;
    end else if (elapsed >= 32'(cfg.timeout_seconds)) begin
      target = item.relay_on ? dim_s : bltf_pkg::LVL_OFF;
    end else begin
      target = bright_s;
    end
  end

  // midpoint between the two table values around a one-level drop
  assign level_dn = level_now - bltf_pkg::LVL_W'(1);
  assign g_hi     = bltf_pkg::gamma_of(level_now);
  assign g_lo     = bltf_pkg::gamma_of(level_dn);
  assign g_min    = (g_hi >= g_lo) ? g_lo : g_hi;
  assign g_diff   = (g_hi >= g_lo) ? (g_hi - g_lo) : (g_lo - g_hi);
  assign g_mid    = (g_diff >> 1) + g_min;

  always_comb begin
    fin.intensity    = (level_dn < 0) ? 8'd0 : g_lo;
    fin.light_off    = (level_dn < 0);
    fin.fade_pending = (target != level_dn);
    fin.last         = 1'b1;
  end

  always_comb begin
    push       = '0;
    level_next = level_now;
    if (advance) begin
      if (target < level_now) begin
        level_next = level_dn;
        if (level_now > bltf_pkg::FADE_STEP_LIMIT) begin
          push.cnt = 2'd2;
          push.r0  = '{intensity: g_mid, light_off: 1'b0, fade_pending: 1'b1, last: 1'b0};
          push.r1  = fin;
        end else begin
          push.cnt = 2'd1;
          push.r0  = fin;
        end
      end else if (target > level_now) begin
        level_next = target;
        push.cnt   = 2'd1;
        push.r0    = '{intensity: bltf_pkg::gamma_of(target), light_off: 1'b0,
                       fade_pending: 1'b0, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      level_now <= bltf_pkg::LVL_W'(bltf_pkg::MAX_LEVEL);
      last_time <= '0;
    end else begin
      in_full <= load | (in_full & ~advance);
      if (advance) begin
        level_now <= level_next;
        if (item.mode) begin
          last_time <= item.time_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_data;
    end
  end

endmodule

// ===== rtl/bltf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bltf_out_fifo
// Small result queue: takes up to two results a cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
module bltf_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  bltf_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output bltf_pkg::out_item_t out_data
);

  bltf_pkg::out_item_t               mem [bltf_pkg::OQ_DEPTH];
  logic [bltf_pkg::OQ_PTR_W-1:0]     head;
  logic [bltf_pkg::OQ_PTR_W-1:0]     tail;
  logic [bltf_pkg::OQ_CNT_W-1:0]     count;
  logic                              pop;
  logic [bltf_pkg::OQ_PTR_W-1:0]     tail_p1;

  assign out_valid = (count != '0);
  assign pop       = out_valid & ~out_stall;
  assign room      = (int'(count) <= bltf_pkg::OQ_DEPTH - 2);
  assign out_data  = mem[head];
  assign tail_p1   = tail + bltf_pkg::OQ_PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + bltf_pkg::OQ_PTR_W'(1);
      end
      tail  <= tail + bltf_pkg::OQ_PTR_W'(push.cnt);
      count <= count + bltf_pkg::OQ_CNT_W'(push.cnt) - bltf_pkg::OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[tail] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[tail_p1] <= push.r1;
    end
  end

endmodule

// ===== rtl/backlight_timeout_fader_top.sv =====
// ----------------------------------------------------------------------------
// backlight_timeout_fader_top
// Backlight level fader with inactivity timeout, dimming and gamma output.
// ----------------------------------------------------------------------------
//  channel  | signals                          | moves
//  ---------+----------------------------------+-------------------------------
//  input    | in_valid, in_stall, in_data      | mode, time_now, relay_on
//  output   | out_valid, out_stall, out_data   | intensity, light_off,
//           |                                  | fade_pending, last
//  config   | cfg_we, cfg_index, cfg_data      | bright, dim, timeout regs
//
//  A request is registered on accept and processed once the 4-entry result
//  queue has two free slots; processing writes its results to the queue.
//  Results leave one per cycle while out_stall is low, through the single
//  result port. A new request can be accepted as the held one is processed;
//  one with no result pushes nothing. Synchronous reset; no clearing pass.
//  out_stall backs up the queue, then the input register, then in_stall.
// ----------------------------------------------------------------------------
module backlight_timeout_fader_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bltf_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bltf_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bltf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  bltf_pkg::cfg_t  cfg;
  bltf_pkg::push_t push;
  logic            room;

  bltf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bltf_step u_step (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .room     (room),
    .push     (push)
  );

  bltf_out_fifo u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room)
    else $error("results pushed without queue room");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd2) |-> (!push.r0.last && push.r1.last && push.r0.fade_pending))
    else $error("midpoint/final pair malformed");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd1) |-> push.r0.last)
    else $error("single result not marked last");

  a_dim_le_bright: assert property (@(posedge clk) disable iff (rst)
    cfg.dim_level <= cfg.bright_level)
    else $error("dim level above bright level");
`endif

endmodule
